// ----- rtl/qrs_pkg.sv -----
package qrs_pkg;

   localparam int CoefW  = 16;
   localparam int DiscW  = 34;
   localparam int RootW  = 32;
   localparam int SqrtW  = 25;   // sqrt of up to 2^49 fits 25 bits
   localparam int RadW   = 50;   // delta << 16, delta >= 0 below 2^33.4
   localparam int NumW   = 35;   // (nb +/- s) * 256 magnitude below 2^34
   localparam int QuoW   = 35;   // quotient magnitude, denominator >= 2
   localparam int DenW   = 17;   // |2a| up to 65536

   localparam logic [1:0] OUT_NONE     = 2'd0;
   localparam logic [1:0] OUT_EQUAL    = 2'd1;
   localparam logic [1:0] OUT_DISTINCT = 2'd2;
   localparam logic [1:0] OUT_ZERO_A   = 2'd3;

   typedef struct packed {
      logic signed [CoefW-1:0] coef_a;
      logic signed [CoefW-1:0] coef_b;
      logic signed [CoefW-1:0] coef_c;
   } req_type;

   typedef struct packed {
      logic signed [DiscW-1:0] discriminant;
      logic signed [RootW-1:0] root_plus;
      logic signed [RootW-1:0] root_minus;
      logic        [1:0]       outcome;
      logic                    saturated;
   } rsp_type;

   // item context that rides along the sqrt and divide pipelines
   typedef struct packed {
      logic signed [DiscW-1:0] disc;
      logic signed [CoefW-1:0] coef_a;
      logic signed [CoefW-1:0] coef_b;
      logic        [1:0]       outcome;
   } ctx_type;

endpackage

// ----- rtl/qrs_disc.sv -----
// discriminant b*b - 4ac, two stages: products then difference
module qrs_disc (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  qrs_pkg::req_type in_req,
   output logic             out_valid,
   output qrs_pkg::ctx_type out_ctx
);
   import qrs_pkg::*;

   logic                    v1_ff, v2_ff;
   logic signed [31:0]      bb_ff, ac_ff;
   logic signed [CoefW-1:0] a1_ff, b1_ff;
   ctx_type                 ctx_ff;
   ctx_type                 ctx_in;
   logic signed [DiscW-1:0] d;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      bb_ff  <= in_req.coef_b * in_req.coef_b;
      ac_ff  <= in_req.coef_a * in_req.coef_c;
      a1_ff  <= in_req.coef_a;
      b1_ff  <= in_req.coef_b;
      ctx_ff <= ctx_in;
   end

   always_comb begin
      d = DiscW'(bb_ff) - (DiscW'(ac_ff) <<< 2);
      ctx_in.disc   = d;
      ctx_in.coef_a = a1_ff;
      ctx_in.coef_b = b1_ff;
      if (a1_ff == '0)
         ctx_in.outcome = OUT_ZERO_A;
      else if (d < 0)
         ctx_in.outcome = OUT_NONE;
      else if (d == '0)
         ctx_in.outcome = OUT_EQUAL;
      else
         ctx_in.outcome = OUT_DISTINCT;
   end

   assign out_valid = v2_ff;
   assign out_ctx   = ctx_ff;
endmodule

// ----- rtl/qrs_sqrt.sv -----
// pipelined restoring square root, one result bit per stage
module qrs_sqrt (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  qrs_pkg::ctx_type in_ctx,
   output logic             out_valid,
   output qrs_pkg::ctx_type out_ctx,
   output logic [qrs_pkg::SqrtW-1:0] out_root
);
   import qrs_pkg::*;

   localparam int RemW = SqrtW + 2;

   logic [SqrtW:0]     v_ff;
   ctx_type            ctx_ff  [SqrtW+1];
   logic [RadW-1:0]    rad_ff  [SqrtW+1];
   logic [RemW-1:0]    rem_ff  [SqrtW+1];
   logic [SqrtW-1:0]   root_ff [SqrtW+1];

   // stage 0 loads radicand (zero for negative discriminant)
   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= in_valid;
      ctx_ff[0]  <= in_ctx;
      rad_ff[0]  <= (in_ctx.disc < 0) ? '0 : {in_ctx.disc[RadW-17:0], 16'h0};
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   for (genvar i = 0; i < SqrtW; i++) begin : g_stage
      logic [RemW-1:0] trial;
      logic [RemW-1:0] cur;
      always_comb begin
         cur   = {rem_ff[i][RemW-3:0], rad_ff[i][RadW-1 -: 2]};
         trial = {root_ff[i], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else       v_ff[i+1] <= v_ff[i];
         ctx_ff[i+1] <= ctx_ff[i];
         rad_ff[i+1] <= rad_ff[i] << 2;
         if (cur >= trial) begin
            rem_ff[i+1]  <= cur - trial;
            root_ff[i+1] <= {root_ff[i][SqrtW-2:0], 1'b1};
         end else begin
            rem_ff[i+1]  <= cur;
            root_ff[i+1] <= {root_ff[i][SqrtW-2:0], 1'b0};
         end
      end
   end

   assign out_valid = v_ff[SqrtW];
   assign out_ctx   = ctx_ff[SqrtW];
   assign out_root  = root_ff[SqrtW];
endmodule

// ----- rtl/qrs_div.sv -----
// two pipelined unsigned dividers on magnitudes, one quotient bit per stage
module qrs_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  qrs_pkg::ctx_type in_ctx,
   input  logic [qrs_pkg::SqrtW-1:0] in_root,
   output logic             out_valid,
   output qrs_pkg::rsp_type out_rsp
);
   import qrs_pkg::*;

   localparam int SumW = NumW + 1;
   localparam int RW   = DenW + 1;

   // pipeline registers, index 0 is the numerator setup stage
   logic [QuoW:0]   v_ff;
   ctx_type         c_ff  [QuoW+1];
   logic [NumW-1:0] pn_ff [QuoW+1], mn_ff [QuoW+1];
   logic [RW-1:0]   pr_ff [QuoW+1], mr_ff [QuoW+1];
   logic [DenW-1:0] d_ff  [QuoW+1];
   logic            ps_ff [QuoW+1], ms_ff [QuoW+1];

   // stage 0: numerators, signs and denominator
   logic signed [SumW-1:0] nb, sp, sm;
   logic                   aneg;

   always_comb begin
      nb   = -(SumW'(in_ctx.coef_b) <<< 8);
      sp   = (nb + SumW'(in_root)) <<< 8;
      sm   = (nb - SumW'(in_root)) <<< 8;
      aneg = in_ctx.coef_a[CoefW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= in_valid;
      c_ff[0]  <= in_ctx;
      pn_ff[0] <= sp[SumW-1] ? NumW'(-sp) : NumW'(sp);
      mn_ff[0] <= sm[SumW-1] ? NumW'(-sm) : NumW'(sm);
      pr_ff[0] <= '0;
      mr_ff[0] <= '0;
      ps_ff[0] <= sp[SumW-1] ^ aneg;
      ms_ff[0] <= sm[SumW-1] ^ aneg;
      d_ff[0]  <= aneg ? DenW'(-(DenW'(in_ctx.coef_a) <<< 1))
                       : DenW'(DenW'(in_ctx.coef_a) <<< 1);
   end

   // long division stages
   for (genvar i = 0; i < QuoW; i++) begin : g_stage
      logic [RW-1:0] pc, mc;
      always_comb begin
         pc = {pr_ff[i][RW-2:0], pn_ff[i][NumW-1]};
         mc = {mr_ff[i][RW-2:0], mn_ff[i][NumW-1]};
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else       v_ff[i+1] <= v_ff[i];
         c_ff[i+1]  <= c_ff[i];
         d_ff[i+1]  <= d_ff[i];
         ps_ff[i+1] <= ps_ff[i];
         ms_ff[i+1] <= ms_ff[i];
         // numerator shifts out at top, quotient bits shift in at bottom
         if (pc >= RW'(d_ff[i])) begin
            pr_ff[i+1] <= pc - RW'(d_ff[i]);
            pn_ff[i+1] <= {pn_ff[i][NumW-2:0], 1'b1};
         end else begin
            pr_ff[i+1] <= pc;
            pn_ff[i+1] <= {pn_ff[i][NumW-2:0], 1'b0};
         end
         if (mc >= RW'(d_ff[i])) begin
            mr_ff[i+1] <= mc - RW'(d_ff[i]);
            mn_ff[i+1] <= {mn_ff[i][NumW-2:0], 1'b1};
         end else begin
            mr_ff[i+1] <= mc;
            mn_ff[i+1] <= {mn_ff[i][NumW-2:0], 1'b0};
         end
      end
   end

   // sign fix, clip and output register
   logic            vo_ff;
   rsp_type         rsp_ff, rsp_in;
   logic signed [QuoW:0] qp, qm;
   logic            satp, satm;
   logic signed [RootW-1:0] rp, rm;

   always_comb begin
      qp = ps_ff[QuoW] ? -$signed({1'b0, pn_ff[QuoW]}) : $signed({1'b0, pn_ff[QuoW]});
      qm = ms_ff[QuoW] ? -$signed({1'b0, mn_ff[QuoW]}) : $signed({1'b0, mn_ff[QuoW]});
      satp = 1'b0;
      satm = 1'b0;
      rp = RootW'(qp);
      rm = RootW'(qm);
      if (qp > (QuoW+1)'(32'sh7FFF_FFFF)) begin
         rp = 32'sh7FFF_FFFF; satp = 1'b1;
      end else if (qp < -(QuoW+1)'(33'sh0_8000_0000)) begin
         rp = 32'sh8000_0000; satp = 1'b1;
      end
      if (qm > (QuoW+1)'(32'sh7FFF_FFFF)) begin
         rm = 32'sh7FFF_FFFF; satm = 1'b1;
      end else if (qm < -(QuoW+1)'(33'sh0_8000_0000)) begin
         rm = 32'sh8000_0000; satm = 1'b1;
      end
      rsp_in.discriminant = c_ff[QuoW].disc;
      rsp_in.outcome      = c_ff[QuoW].outcome;
      if (c_ff[QuoW].outcome == OUT_EQUAL || c_ff[QuoW].outcome == OUT_DISTINCT) begin
         rsp_in.root_plus  = rp;
         rsp_in.root_minus = rm;
         rsp_in.saturated  = satp | satm;
      end else begin
         rsp_in.root_plus  = '0;
         rsp_in.root_minus = '0;
         rsp_in.saturated  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else       vo_ff <= v_ff[QuoW];
      rsp_ff <= rsp_in;
   end

   assign out_valid = vo_ff;
   assign out_rsp   = rsp_ff;
endmodule

// ----- rtl/quadratic_root_solver.sv -----
// Quadratic root solver, fixed point.
// Request: drive req_data (a, b, c in signed Q8.8) with start high; the
// transfer happens at a rising edge where start is high and busy is low.
// busy is always low, so a new set of coefficients is taken every cycle.
// Response: rsp_valid is high for exactly one cycle with rsp_data holding
// the discriminant (Q16.16), both roots (Q16.16), the outcome code and the
// saturation flag. The receiver cannot hold results off.
// Pipeline: the discriminant stages, the square root (one result bit per
// stage), numerator setup, the dividers (one quotient bit per stage) and
// the output register.
// Throughput: one item per cycle; the bit-per-stage sqrt and divide
// pipelines set the depth, not the rate.
// Reset: synchronous, clears all valid bits; items in flight are dropped.
// Results leave in the order the requests came in.
module quadratic_root_solver (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qrs_pkg::req_type req_data,
   output logic             rsp_valid,
   output qrs_pkg::rsp_type rsp_data
);
   import qrs_pkg::*;

   logic    dv, sv;
   ctx_type dctx, sctx;
   logic [SqrtW-1:0] sroot;

   assign busy = 1'b0;

   qrs_disc u_disc (
      .clock(clock), .reset(reset), .in_valid(start), .in_req(req_data),
      .out_valid(dv), .out_ctx(dctx)
   );

   qrs_sqrt u_sqrt (
      .clock(clock), .reset(reset), .in_valid(dv), .in_ctx(dctx),
      .out_valid(sv), .out_ctx(sctx), .out_root(sroot)
   );

   qrs_div u_div (
      .clock(clock), .reset(reset), .in_valid(sv), .in_ctx(sctx),
      .in_root(sroot), .out_valid(rsp_valid), .out_rsp(rsp_data)
   );

   // zero a leaves root_plus at zero and saturated low
   a_zero_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome == OUT_ZERO_A |->
         rsp_data.root_plus == '0 && !rsp_data.saturated)
      else $error("roots set for zero a");

   // equal roots agree
   a_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome == OUT_EQUAL |->
         rsp_data.root_plus == rsp_data.root_minus)
      else $error("equal roots differ");

   // nothing emerges right after reset
   a_flush: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule
